FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the battery power mode manager.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BPM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define BPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// Widths, codes, reset values and shared types of the power mode manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpm_pkg;

  localparam int MV_W          = 16;
  localparam int PCT_W         = 7;
  localparam int MODE_W        = 2;
  localparam int MASK_W        = 5;
  localparam int CMD_W         = 2;
  localparam int CLS_W         = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int NUMER_W       = MV_W + PCT_W;   // (mv - empty) * 100
  localparam int CHECK_PHASE_W = 4;
  localparam int WAKE_PHASE_W  = 6;
  localparam int QUEUE_DEPTH   = 2;

  localparam int DEF_CHECK_PERIOD = 10;
  localparam int DEF_WAKE_PERIOD  = 60;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PERIPH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd3;

  // power modes
  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LIGHT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALERT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DEEP   = 2'd3;

  localparam logic [MASK_W-1:0] ALL_PERIPHS       = 5'h1F;
  localparam logic [MASK_W-1:0] LIGHT_OFF_PERIPHS = 5'h0C;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // voltage classes from the front end
  localparam logic [CLS_W-1:0] CLS_ERR  = 2'd0;  // zero reading, ADC failure
  localparam logic [CLS_W-1:0] CLS_ZERO = 2'd1;  // at or below empty
  localparam logic [CLS_W-1:0] CLS_FULL = 2'd2;  // at or above full
  localparam logic [CLS_W-1:0] CLS_DIV  = 2'd3;  // needs interpolation

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT  = 2'd3;

  localparam logic [MV_W-1:0]  EMPTY_RST = 16'd3300;
  localparam logic [MV_W-1:0]  FULL_RST  = 16'd4200;
  localparam logic [PCT_W-1:0] LOW_RST   = 7'd20;
  localparam logic [PCT_W-1:0] CRIT_RST  = 7'd5;

  typedef struct packed {
    logic [MV_W-1:0]  floor_mv;
    logic [MV_W-1:0]  full_mv;
    logic [PCT_W-1:0] low_pct;
    logic [PCT_W-1:0] crit_pct;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [MODE_W-1:0]  req;
    logic [MASK_W-1:0]  sel;
    logic               on;
    logic [CLS_W-1:0]   cls;
    logic [NUMER_W-1:0] numer;
  } entry_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [MASK_W-1:0] mask;
    logic              low;
    logic              crit;
    logic              measured;
    logic [PCT_W-1:0]  pct;
    logic              err;
  } result_t;

endpackage

FILE: rtl/core/bpm_ifs.sv
// ----------------------------------------------------------------------------
// bpm channel interfaces
// Command input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bpm_in_if;
  logic                           valid;
  logic                           ready;
  logic [bpm_pkg::CMD_W-1:0]      command;
  logic [bpm_pkg::MV_W-1:0]       battery_millivolts;
  logic [bpm_pkg::MODE_W-1:0]     requested_mode;
  logic [bpm_pkg::MASK_W-1:0]     peripheral_select;
  logic                           power_on;

  modport source (output valid, command, battery_millivolts, requested_mode,
                  peripheral_select, power_on, input ready);
  modport sink   (input valid, command, battery_millivolts, requested_mode,
                  peripheral_select, power_on, output ready);
endinterface

interface bpm_out_if;
  logic                        valid;
  logic                        ready;
  logic [bpm_pkg::MODE_W-1:0]  mode_now;
  logic [bpm_pkg::MASK_W-1:0]  powered_mask;
  logic                        low_alert;
  logic                        critical_alert;
  logic                        measured;
  logic [bpm_pkg::PCT_W-1:0]   battery_percent;
  logic                        adc_error;

  modport source (output valid, mode_now, powered_mask, low_alert, critical_alert,
                  measured, battery_percent, adc_error, input ready);
  modport sink   (input valid, mode_now, powered_mask, low_alert, critical_alert,
                  measured, battery_percent, adc_error, output ready);
endinterface

interface bpm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bpm_pkg::CFG_IDX_W-1:0]    index;
  logic [bpm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/bpm_front.sv
// ----------------------------------------------------------------------------
// bpm_front
// Accepts command transactions, classifies the battery reading against the
// empty/full window and forms the interpolation numerator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bpm_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bpm_pkg::CMD_W-1:0]   in_cmd,
  input  logic [bpm_pkg::MV_W-1:0]    in_mv,
  input  logic [bpm_pkg::MODE_W-1:0]  in_req,
  input  logic [bpm_pkg::MASK_W-1:0]  in_sel,
  input  logic                        in_on,
  output logic                        fr_valid,
  input  logic                        fr_ready,
  output bpm_pkg::entry_t             fr_entry
);

  logic            fr_valid_r;
  bpm_pkg::entry_t fr_entry_r;
  bpm_pkg::entry_t entry_nxt;
  logic [bpm_pkg::MV_W-1:0] diff;

  assign in_ready = !fr_valid_r || fr_ready;
  assign fr_valid = fr_valid_r;
  assign fr_entry = fr_entry_r;

  always_comb begin
    diff            = in_mv - cfg.floor_mv;
    entry_nxt.cmd   = in_cmd;
    entry_nxt.req   = in_req;
    entry_nxt.sel   = in_sel;
    entry_nxt.on    = in_on;
    entry_nxt.numer = bpm_pkg::NUMER_W'(diff) * bpm_pkg::NUMER_W'(bpm_pkg::PCT_FULL);
    // order matters: a window with empty >= full reads full above empty
    priority if (in_mv == '0) begin
      entry_nxt.cls = bpm_pkg::CLS_ERR;
    end else if (in_mv <= cfg.floor_mv) begin
      entry_nxt.cls = bpm_pkg::CLS_ZERO;
    end else if (in_mv >= cfg.full_mv) begin
      entry_nxt.cls = bpm_pkg::CLS_FULL;
    end else begin
      entry_nxt.cls = bpm_pkg::CLS_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      fr_valid_r <= 1'b1;
    end else if (fr_ready) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_entry_r <= entry_nxt;
    end
  end

endmodule

FILE: rtl/core/bpm_queue.sv
// ----------------------------------------------------------------------------
// bpm_queue
// Short FIFO of classified commands between the front end and the executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  bpm_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bpm_pkg::entry_t pop_entry
);

  localparam int PTR_W = (bpm_pkg::QUEUE_DEPTH > 1) ? $clog2(bpm_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(bpm_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(bpm_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(bpm_pkg::QUEUE_DEPTH);

  bpm_pkg::entry_t   slot_r [bpm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/core/bpm_div.sv
// ----------------------------------------------------------------------------
// bpm_div
// Restoring divider producing the seven-bit percent, one quotient bit per
// cycle. The quotient is known to stay below 128.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bpm_pkg::NUMER_W-1:0]   numer,
  input  logic [bpm_pkg::MV_W-1:0]      denom,
  output logic                          done,
  output logic [bpm_pkg::PCT_W-1:0]     quot
);

  localparam int CNT_W = $clog2(bpm_pkg::PCT_W + 1);

  logic [bpm_pkg::NUMER_W-1:0] rem_r, ds_r;
  logic [bpm_pkg::PCT_W-1:0]   q_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r, done_r;
  logic                        ge;

  assign ge   = (rem_r >= ds_r);
  assign done = done_r;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(bpm_pkg::PCT_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CNT_W'(1));
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= numer;
      ds_r  <= bpm_pkg::NUMER_W'(denom) << (bpm_pkg::PCT_W - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - ds_r;
      end
      ds_r <= ds_r >> 1;
      q_r  <= {q_r[bpm_pkg::PCT_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/core/bpm_back.sv
// ----------------------------------------------------------------------------
// bpm_back
// Executes queued commands: holds the power mode, peripheral mask, alert
// flags and tick phases, runs the percent division and registers results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpm_back #(
  parameter int CHECK_PERIOD = bpm_pkg::DEF_CHECK_PERIOD,
  parameter int WAKE_PERIOD  = bpm_pkg::DEF_WAKE_PERIOD
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bpm_pkg::cfg_t    cfg,
  input  logic             q_valid,
  output logic             q_ready,
  input  bpm_pkg::entry_t  q_entry,
  output logic             res_valid,
  input  logic             res_ready,
  output bpm_pkg::result_t res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  localparam int CP_W = bpm_pkg::CHECK_PHASE_W;
  localparam int WP_W = bpm_pkg::WAKE_PHASE_W;

  typedef struct packed {
    logic [bpm_pkg::MODE_W-1:0] mode;
    logic [bpm_pkg::MASK_W-1:0] mask;
  } mm_t;

  function automatic mm_t change_mode(mm_t cur, logic [bpm_pkg::MODE_W-1:0] target);
    mm_t nx;
    nx = cur;
    if (target != cur.mode) begin
      unique case (target)
        bpm_pkg::MODE_NORMAL: nx.mask = bpm_pkg::ALL_PERIPHS;
        bpm_pkg::MODE_LIGHT:  nx.mask = cur.mask & ~bpm_pkg::LIGHT_OFF_PERIPHS;
        bpm_pkg::MODE_DEEP:   nx.mask = '0;
        default:              nx.mask = cur.mask;   // alert keeps the mask
      endcase
      nx.mode = target;
    end
    return nx;
  endfunction

  logic [1:0]                state_r, state_nxt;
  bpm_pkg::entry_t           entry_r;
  logic [bpm_pkg::PCT_W-1:0] pct_r;

  mm_t                       mm_r, mm_nxt;
  logic                      low_r, low_nxt;
  logic                      crit_r, crit_nxt;
  logic [CP_W-1:0]           cp_r, cp_nxt;
  logic [WP_W-1:0]           wp_r, wp_nxt;

  logic                      out_valid_r;
  bpm_pkg::result_t          out_res_r, res_nxt;

  logic                      pop, commit, div_start, div_done;
  logic [bpm_pkg::PCT_W-1:0] div_quot;
  logic [bpm_pkg::MV_W-1:0]  span;
  logic                      needs_div;

  logic [CP_W:0]             cp_inc;
  logic [WP_W:0]             wp_inc;
  logic [CP_W-1:0]           cp1;
  logic [WP_W-1:0]           wp1;
  logic                      err, is_low, is_crit, checked;

  assign q_ready   = (state_r == S_IDLE);
  assign pop       = q_valid && q_ready;
  assign needs_div = ((q_entry.cmd == bpm_pkg::CMD_TICK) ||
                      (q_entry.cmd == bpm_pkg::CMD_CHECK)) &&
                     (q_entry.cls == bpm_pkg::CLS_DIV);
  assign div_start = pop && needs_div;
  assign span      = cfg.full_mv - cfg.floor_mv;
  assign commit    = (state_r == S_APPLY) && (!out_valid_r || res_ready);

  assign res_valid = out_valid_r;
  assign res       = out_res_r;

  bpm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (q_entry.numer),
    .denom (span),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (pop) state_nxt = needs_div ? S_DIV : S_APPLY;
      S_DIV:   if (div_done) state_nxt = S_APPLY;
      S_APPLY: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Both checks of one tick see the same reading, so one percent serves both.
  always_comb begin
    cp_inc  = {1'b0, cp_r} + 1'b1;
    wp_inc  = {1'b0, wp_r} + 1'b1;
    cp1     = (cp_inc >= (CP_W + 1)'(CHECK_PERIOD)) ? '0 : cp_inc[CP_W-1:0];
    wp1     = (wp_inc >= (WP_W + 1)'(WAKE_PERIOD)) ? '0 : wp_inc[WP_W-1:0];
    err     = (entry_r.cls == bpm_pkg::CLS_ERR);
    is_low  = !err && (pct_r <= cfg.low_pct);
    is_crit = !err && (pct_r <= cfg.crit_pct);

    mm_nxt   = mm_r;
    low_nxt  = low_r;
    crit_nxt = crit_r;
    cp_nxt   = cp_r;
    wp_nxt   = wp_r;
    checked  = 1'b0;

    unique case (entry_r.cmd)
      bpm_pkg::CMD_TICK: begin
        cp_nxt = cp1;
        wp_nxt = wp1;
        if (cp1 == '0) begin
          checked = 1'b1;
          if (!err) begin
            low_nxt  = is_low;
            crit_nxt = is_crit;
          end
          if (is_low && (mm_nxt.mode == bpm_pkg::MODE_NORMAL)) begin
            mm_nxt = change_mode(mm_nxt, bpm_pkg::MODE_LIGHT);
          end
          if (is_crit && (mm_nxt.mode != bpm_pkg::MODE_DEEP)) begin
            mm_nxt = change_mode(mm_nxt, bpm_pkg::MODE_DEEP);
          end
        end
        if ((mm_nxt.mode == bpm_pkg::MODE_LIGHT) && (wp1 == '0)) begin
          checked = 1'b1;
          if (!err) begin
            low_nxt  = is_low;
            crit_nxt = is_crit;
          end
          // an ADC error counts as above the low threshold here
          if (!is_low) begin
            mm_nxt = change_mode(mm_nxt, bpm_pkg::MODE_NORMAL);
          end
        end
      end
      bpm_pkg::CMD_SET: begin
        mm_nxt = change_mode(mm_r, entry_r.req);
      end
      bpm_pkg::CMD_PERIPH: begin
        mm_nxt.mask = entry_r.on ? (mm_r.mask | entry_r.sel) : (mm_r.mask & ~entry_r.sel);
      end
      bpm_pkg::CMD_CHECK: begin
        checked = 1'b1;
        if (!err) begin
          low_nxt  = is_low;
          crit_nxt = is_crit;
        end
      end
      default: ;
    endcase

    res_nxt.mode     = mm_nxt.mode;
    res_nxt.mask     = mm_nxt.mask;
    res_nxt.low      = low_nxt;
    res_nxt.crit     = crit_nxt;
    res_nxt.measured = checked;
    res_nxt.err      = checked && err;
    res_nxt.pct      = (checked && !err) ? pct_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mm_r.mode   <= bpm_pkg::MODE_NORMAL;
      mm_r.mask   <= bpm_pkg::ALL_PERIPHS;
      low_r       <= 1'b0;
      crit_r      <= 1'b0;
      cp_r        <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        mm_r        <= mm_nxt;
        low_r       <= low_nxt;
        crit_r      <= crit_nxt;
        cp_r        <= cp_nxt;
        wp_r        <= wp_nxt;
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      entry_r <= q_entry;
      pct_r   <= (q_entry.cls == bpm_pkg::CLS_FULL) ? bpm_pkg::PCT_FULL : '0;
    end else if ((state_r == S_DIV) && div_done) begin
      pct_r <= div_quot;
    end
    if (commit) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

FILE: rtl/core/battery_power_mode_manager_unit.sv
// ----------------------------------------------------------------------------
// battery_power_mode_manager_unit
// Power mode manager for a battery device. Each command transaction yields
// one result transaction with the mode, peripheral mask and alert flags after
// the command, plus the battery check report. A classifying front stage feeds
// a two-entry queue, and an executor drains it. The executor pops an entry and
// applies it directly when no interpolation is needed (mode and peripheral
// commands, and tick or check readings that are zero, at or below empty, or at
// or above full). When a tick or check reading lies inside the empty/full
// window, it first runs the seven one-bit-per-cycle steps of the percent
// divider. The executor takes no new command until it has applied the last.
// Config registers are to be written by the user only with the block idle;
// the block itself does not enforce this. They take effect on the next
// command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module battery_power_mode_manager_unit #(
  parameter int CHECK_PERIOD = bpm_pkg::DEF_CHECK_PERIOD,
  parameter int WAKE_PERIOD  = bpm_pkg::DEF_WAKE_PERIOD
) (
  input  logic      clk,
  input  logic      rst_n,
  bpm_in_if.sink    in_if,
  bpm_out_if.source out_if,
  bpm_cfg_if.sink   cfg_if
);

  bpm_pkg::cfg_t    cfg_r;
  logic             fr_valid, fr_ready;
  bpm_pkg::entry_t  fr_entry;
  logic             q_valid, q_ready;
  bpm_pkg::entry_t  q_entry;
  bpm_pkg::result_t res;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.floor_mv <= bpm_pkg::EMPTY_RST;
      cfg_r.full_mv  <= bpm_pkg::FULL_RST;
      cfg_r.low_pct  <= bpm_pkg::LOW_RST;
      cfg_r.crit_pct <= bpm_pkg::CRIT_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.index)
        bpm_pkg::CFG_EMPTY: cfg_r.floor_mv <= cfg_if.data[bpm_pkg::MV_W-1:0];
        bpm_pkg::CFG_FULL:  cfg_r.full_mv  <= cfg_if.data[bpm_pkg::MV_W-1:0];
        bpm_pkg::CFG_LOW:   cfg_r.low_pct  <= cfg_if.data[bpm_pkg::PCT_W-1:0];
        bpm_pkg::CFG_CRIT:  cfg_r.crit_pct <= cfg_if.data[bpm_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  bpm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_cmd   (in_if.command),
    .in_mv    (in_if.battery_millivolts),
    .in_req   (in_if.requested_mode),
    .in_sel   (in_if.peripheral_select),
    .in_on    (in_if.power_on),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_entry (fr_entry)
  );

  bpm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_entry (fr_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_entry  (q_entry)
  );

  bpm_back #(
    .CHECK_PERIOD (CHECK_PERIOD),
    .WAKE_PERIOD  (WAKE_PERIOD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .res_valid (out_if.valid),
    .res_ready (out_if.ready),
    .res       (res)
  );

  assign out_if.mode_now        = res.mode;
  assign out_if.powered_mask    = res.mask;
  assign out_if.low_alert       = res.low;
  assign out_if.critical_alert  = res.crit;
  assign out_if.measured        = res.measured;
  assign out_if.battery_percent = res.pct;
  assign out_if.adc_error       = res.err;

  `BPM_ASSERT_IMPLIES(a_no_check_no_report, clk, rst_n, out_if.valid && !out_if.measured, out_if.battery_percent == '0 && !out_if.adc_error)
  `BPM_ASSERT_IMPLIES(a_adc_err_zero_pct, clk, rst_n, out_if.valid && out_if.adc_error, out_if.measured && out_if.battery_percent == '0)
  `BPM_ASSERT_IMPLIES(a_pct_in_range, clk, rst_n, out_if.valid, out_if.battery_percent <= bpm_pkg::PCT_FULL)
  `BPM_ASSERT_NEXT(a_front_loaded, clk, rst_n, in_if.valid && in_if.ready, fr_valid)

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for battery_power_mode_manager_unit. Directed command
// rows run first, then random traffic across several threshold settings,
// with light sleep soak runs that reach the periodic checks and the wake
// check. Every result transaction is compared field by field against a typed row's
// expected result or an in-bench model of the mode, mask, alert flags and tick phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [bpm_pkg::CMD_W-1:0]  cmd;
    logic [bpm_pkg::MV_W-1:0]   mv;
    logic [bpm_pkg::MODE_W-1:0] req;
    logic [bpm_pkg::MASK_W-1:0] sel;
    logic                       pwr_on;
  } cmd_item_t;

  typedef struct packed {
    cmd_item_t        item;
    logic             typed;   // row carries its own expected result
    bpm_pkg::result_t want;
  } dir_row_t;

  localparam bpm_pkg::result_t NO_RES   = '0;
  localparam int               DIR_ROWS = 24;
  localparam int               PHASES   = 7;
  localparam int               PHASE_ITEMS = 32;

  logic clk = 1'b0;
  logic rst_n;

  bpm_in_if  cmd_bus ();
  bpm_out_if res_bus ();
  bpm_cfg_if cfg_bus ();

  battery_power_mode_manager_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cmd_bus),
    .out_if (res_bus),
    .cfg_if (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model of the thresholds and of the manager state
  logic [bpm_pkg::MV_W-1:0]   lim_empty = bpm_pkg::EMPTY_RST;
  logic [bpm_pkg::MV_W-1:0]   lim_full  = bpm_pkg::FULL_RST;
  logic [bpm_pkg::PCT_W-1:0]  lim_low   = bpm_pkg::LOW_RST;
  logic [bpm_pkg::PCT_W-1:0]  lim_crit  = bpm_pkg::CRIT_RST;
  logic [bpm_pkg::MODE_W-1:0] pm_mode   = bpm_pkg::MODE_NORMAL;
  logic [bpm_pkg::MASK_W-1:0] pm_mask   = bpm_pkg::ALL_PERIPHS;
  logic                       pm_low    = 1'b0;
  logic                       pm_crit   = 1'b0;
  int unsigned                pm_check_ph = 0;
  int unsigned                pm_wake_ph  = 0;
  // battery check report of the current command
  logic                       rep_measured;
  logic [bpm_pkg::PCT_W-1:0]  rep_level;
  logic                       rep_fault;

  bpm_pkg::result_t pending_results[$];
  int               fault_count = 0;
  bit               src_quiet   = 1'b0;
  bit               sink_quiet  = 1'b0;
  int               sink_hold   = 0;
  bpm_pkg::result_t seen_res, due_res;

  dir_row_t directed_tab [DIR_ROWS] = '{
    // ADC error, full scale, reading at empty
    '{'{bpm_pkg::CMD_CHECK, 16'd0, bpm_pkg::MODE_NORMAL, 5'h00, 1'b0}, 1'b1,
      '{bpm_pkg::MODE_NORMAL, bpm_pkg::ALL_PERIPHS, 1'b0, 1'b0, 1'b1, 7'd0, 1'b1}},
    '{'{bpm_pkg::CMD_CHECK, 16'hFFFF, bpm_pkg::MODE_DEEP, 5'h1F, 1'b1}, 1'b1,
      '{bpm_pkg::MODE_NORMAL, bpm_pkg::ALL_PERIPHS, 1'b0, 1'b0, 1'b1,
        bpm_pkg::PCT_FULL, 1'b0}},
    '{'{bpm_pkg::CMD_CHECK, bpm_pkg::EMPTY_RST, bpm_pkg::MODE_NORMAL, 5'h00, 1'b0}, 1'b1,
      '{bpm_pkg::MODE_NORMAL, bpm_pkg::ALL_PERIPHS, 1'b1, 1'b1, 1'b1, 7'd0, 1'b0}},
    '{'{bpm_pkg::CMD_CHECK, 16'd3750, bpm_pkg::MODE_LIGHT, 5'h15, 1'b1}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_CHECK, 16'd3301, bpm_pkg::MODE_ALERT, 5'h0A, 1'b0}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_CHECK, 16'd4199, bpm_pkg::MODE_NORMAL, 5'h00, 1'b0}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_PERIPH, 16'hFFFF, bpm_pkg::MODE_DEEP, bpm_pkg::ALL_PERIPHS, 1'b0},
      1'b1, '{bpm_pkg::MODE_NORMAL, 5'h00, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0}},
    '{'{bpm_pkg::CMD_PERIPH, 16'd0, bpm_pkg::MODE_NORMAL, 5'h0A, 1'b1}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_SET, 16'd1234, bpm_pkg::MODE_LIGHT, 5'h15, 1'b1}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_SET, 16'd0, bpm_pkg::MODE_LIGHT, 5'h00, 1'b0}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_SET, 16'd0, bpm_pkg::MODE_ALERT, 5'h00, 1'b0}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_SET, 16'd0, bpm_pkg::MODE_DEEP, 5'h00, 1'b0}, 1'b1,
      '{bpm_pkg::MODE_DEEP, 5'h00, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0}},
    '{'{bpm_pkg::CMD_SET, 16'd0, bpm_pkg::MODE_NORMAL, 5'h00, 1'b0}, 1'b1,
      '{bpm_pkg::MODE_NORMAL, bpm_pkg::ALL_PERIPHS, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0}},
    // nine ticks without a check, then the tenth checks a low battery
    '{'{bpm_pkg::CMD_TICK, 16'd0, bpm_pkg::MODE_NORMAL, 5'h00, 1'b0}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_TICK, 16'hFFFF, bpm_pkg::MODE_DEEP, 5'h1F, 1'b1}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_TICK, 16'd3300, bpm_pkg::MODE_NORMAL, 5'h00, 1'b0}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_TICK, 16'd100, bpm_pkg::MODE_LIGHT, 5'h00, 1'b0}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_TICK, 16'h8000, bpm_pkg::MODE_NORMAL, 5'h00, 1'b0}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_TICK, 16'd4200, bpm_pkg::MODE_NORMAL, 5'h00, 1'b0}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_TICK, 16'd1, bpm_pkg::MODE_NORMAL, 5'h00, 1'b0}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_TICK, 16'h7FFF, bpm_pkg::MODE_NORMAL, 5'h00, 1'b0}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_TICK, 16'd3500, bpm_pkg::MODE_NORMAL, 5'h00, 1'b0}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_TICK, 16'd3400, bpm_pkg::MODE_NORMAL, 5'h00, 1'b0}, 1'b0, NO_RES},
    '{'{bpm_pkg::CMD_CHECK, 16'd3310, bpm_pkg::MODE_NORMAL, 5'h00, 1'b0}, 1'b0, NO_RES}
  };

  // ---------------- model ----------------

  task automatic measure_battery(input logic [bpm_pkg::MV_W-1:0] mv,
                                 output int unsigned level);
    int unsigned span, num;
    rep_measured = 1'b1;
    if (mv == 0) begin
      rep_fault = 1'b1;
      rep_level = '0;
      level = 255;   // error reads above every threshold
    end else begin
      if (mv <= lim_empty) begin
        level = 0;
      end else if (mv >= lim_full) begin
        level = 100;
      end else begin
        span  = int'(lim_full) - int'(lim_empty);
        num   = (int'(mv) - int'(lim_empty)) * 100;
        level = num / span;
      end
      pm_low    = (level <= lim_low);
      pm_crit   = (level <= lim_crit);
      rep_level = level[bpm_pkg::PCT_W-1:0];
    end
  endtask

  task automatic enter_mode(input logic [bpm_pkg::MODE_W-1:0] m);
    if (m != pm_mode) begin
      case (m)
        bpm_pkg::MODE_NORMAL: pm_mask = bpm_pkg::ALL_PERIPHS;
        bpm_pkg::MODE_LIGHT:  pm_mask = pm_mask & ~bpm_pkg::LIGHT_OFF_PERIPHS;
        bpm_pkg::MODE_DEEP:   pm_mask = '0;
        default:              ;
      endcase
      pm_mode = m;
    end
  endtask

  task automatic predict_step(input cmd_item_t it, output bpm_pkg::result_t r);
    int unsigned level;
    rep_measured = 1'b0;
    rep_fault    = 1'b0;
    rep_level    = '0;
    case (it.cmd)
      bpm_pkg::CMD_TICK: begin
        pm_check_ph = (pm_check_ph + 1 >= bpm_pkg::DEF_CHECK_PERIOD) ? 0 : pm_check_ph + 1;
        pm_wake_ph  = (pm_wake_ph + 1 >= bpm_pkg::DEF_WAKE_PERIOD) ? 0 : pm_wake_ph + 1;
        if (pm_check_ph == 0) begin
          measure_battery(it.mv, level);
          if (level <= lim_low && pm_mode == bpm_pkg::MODE_NORMAL)
            enter_mode(bpm_pkg::MODE_LIGHT);
          if (level <= lim_crit && pm_mode != bpm_pkg::MODE_DEEP)
            enter_mode(bpm_pkg::MODE_DEEP);
        end
        if (pm_mode == bpm_pkg::MODE_LIGHT && pm_wake_ph == 0) begin
          measure_battery(it.mv, level);
          if (level > lim_low) enter_mode(bpm_pkg::MODE_NORMAL);
        end
      end
      bpm_pkg::CMD_SET: enter_mode(it.req);
      bpm_pkg::CMD_PERIPH: pm_mask = it.pwr_on ? (pm_mask | it.sel) : (pm_mask & ~it.sel);
      default: measure_battery(it.mv, level);
    endcase
    r = '{pm_mode, pm_mask, pm_low, pm_crit, rep_measured, rep_level, rep_fault};
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic int gap_cycles();
    int unsigned r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [bpm_pkg::MV_W-1:0] near_value(input int unsigned x);
    int unsigned v = x;
    case ($urandom_range(0, 2))
      1: if (v < 65535) v++;
      2: if (v > 0) v--;
      default: ;
    endcase
    return bpm_pkg::MV_W'(v);
  endfunction

  function automatic logic [bpm_pkg::MV_W-1:0] pick_voltage();
    int unsigned r = $urandom_range(0, 99);
    int unsigned e = lim_empty;
    int unsigned f = lim_full;
    if (r < 6) return '0;
    if (r < 16) return bpm_pkg::MV_W'($urandom);
    if (r < 24) return near_value(e);
    if (r < 32) return near_value(f);
    if (f > e) return bpm_pkg::MV_W'($urandom_range(e, f));
    return bpm_pkg::MV_W'($urandom_range(0, 65535));
  endfunction

  // mostly above mid scale so that light sleep survives to the wake check
  function automatic logic [bpm_pkg::MV_W-1:0] healthy_voltage();
    int unsigned e = lim_empty;
    int unsigned f = lim_full;
    if (f > e + 1 && $urandom_range(0, 3) != 0)
      return bpm_pkg::MV_W'($urandom_range((e + f) / 2 + 1, f));
    return pick_voltage();
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t it;
    int unsigned r = $urandom_range(0, 99);
    if (r < 60)      it.cmd = bpm_pkg::CMD_TICK;
    else if (r < 72) it.cmd = bpm_pkg::CMD_SET;
    else if (r < 84) it.cmd = bpm_pkg::CMD_PERIPH;
    else             it.cmd = bpm_pkg::CMD_CHECK;
    it.mv     = pick_voltage();
    it.req    = bpm_pkg::MODE_W'($urandom);
    it.sel    = bpm_pkg::MASK_W'($urandom);
    it.pwr_on = 1'($urandom);
    return it;
  endfunction

  // entered and left at a falling edge; valid stays high after the transaction
  task automatic send_item(input cmd_item_t it, input logic typed,
                           input bpm_pkg::result_t want);
    int gap;
    bpm_pkg::result_t r;
    gap = src_quiet ? 0 : gap_cycles();
    if (gap != 0) begin
      cmd_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_bus.command            = it.cmd;
    cmd_bus.battery_millivolts = it.mv;
    cmd_bus.requested_mode     = it.req;
    cmd_bus.peripheral_select  = it.sel;
    cmd_bus.power_on           = it.pwr_on;
    cmd_bus.valid              = 1'b1;
    do @(posedge clk); while (!cmd_bus.ready);
    predict_step(it, r);
    pending_results.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic hold_and_drain();
    cmd_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic put_reg(input logic [bpm_pkg::CFG_IDX_W-1:0] idx,
                         input logic [bpm_pkg::CFG_DATA_W-1:0] data);
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    cfg_bus.valid = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      bpm_pkg::CFG_EMPTY: lim_empty = data;
      bpm_pkg::CFG_FULL:  lim_full  = data;
      bpm_pkg::CFG_LOW:   lim_low   = data[bpm_pkg::PCT_W-1:0];
      bpm_pkg::CFG_CRIT:  lim_crit  = data[bpm_pkg::PCT_W-1:0];
      default:            ;
    endcase
    @(negedge clk);
  endtask

  // ---------------- result side ----------------

  always @(negedge clk) begin
    if (sink_hold != 0) begin
      res_bus.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      res_bus.ready <= 1'b1;
      if (!sink_quiet && $urandom_range(0, 3) == 0) sink_hold <= gap_cycles();
    end
  end

  task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      seen_res = '{res_bus.mode_now, res_bus.powered_mask, res_bus.low_alert,
                   res_bus.critical_alert, res_bus.measured, res_bus.battery_percent,
                   res_bus.adc_error};
      if (pending_results.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result, expected none, got %h", $time, seen_res);
      end else begin
        due_res = pending_results.pop_front();
        check_field("mode_now", 8'(due_res.mode), 8'(seen_res.mode));
        check_field("powered_mask", 8'(due_res.mask), 8'(seen_res.mask));
        check_field("low_alert", 8'(due_res.low), 8'(seen_res.low));
        check_field("critical_alert", 8'(due_res.crit), 8'(seen_res.crit));
        check_field("measured", 8'(due_res.measured), 8'(seen_res.measured));
        check_field("battery_percent", 8'(due_res.pct), 8'(seen_res.pct));
        check_field("adc_error", 8'(due_res.err), 8'(seen_res.err));
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    cmd_item_t   it;
    int          sent, n;
    int unsigned e, f, l, c;
    rst_n                      = 1'b0;
    cmd_bus.valid              = 1'b0;
    cmd_bus.command            = bpm_pkg::CMD_TICK;
    cmd_bus.battery_millivolts = '0;
    cmd_bus.requested_mode     = bpm_pkg::MODE_NORMAL;
    cmd_bus.peripheral_select  = '0;
    cmd_bus.power_on           = 1'b0;
    cfg_bus.valid              = 1'b0;
    cfg_bus.index              = bpm_pkg::CFG_EMPTY;
    cfg_bus.data               = '0;
    res_bus.ready              = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(directed_tab[i].item, directed_tab[i].typed, directed_tab[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        hold_and_drain();
        case (ph)
          1: begin e = 0;     f = 65535; l = 0;   c = 0;   end
          2: begin e = 65535; f = 0;     l = 100; c = 100; end
          3: begin e = 1000;  f = 1000;  l = 127; c = 50;  end  // low threshold past 100
          4: begin e = 3000;  f = 3010;  l = 50;  c = 10;  end
          5: begin
            e = $urandom_range(0, 60000);
            f = $urandom_range(e + 1, 65535);
            l = $urandom_range(0, 100);
            c = $urandom_range(0, l);
          end
          default: begin
            e = bpm_pkg::EMPTY_RST;
            f = bpm_pkg::FULL_RST;
            l = bpm_pkg::LOW_RST;
            c = bpm_pkg::CRIT_RST;
          end
        endcase
        // upper data bits of the percent registers are don't care
        put_reg(bpm_pkg::CFG_EMPTY, bpm_pkg::CFG_DATA_W'(e));
        put_reg(bpm_pkg::CFG_FULL, bpm_pkg::CFG_DATA_W'(f));
        put_reg(bpm_pkg::CFG_LOW, {9'($urandom), bpm_pkg::PCT_W'(l)});
        put_reg(bpm_pkg::CFG_CRIT, {9'($urandom), bpm_pkg::PCT_W'(c)});
        cfg_bus.valid = 1'b0;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        src_quiet  = ($urandom_range(0, 3) == 0);
        sink_quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 12) hold_and_drain();
        if ($urandom_range(0, 99) < 40) begin
          // light sleep soak: long enough to pass a wake check
          it     = random_item();
          it.cmd = bpm_pkg::CMD_SET;
          it.req = bpm_pkg::MODE_LIGHT;
          send_item(it, 1'b0, NO_RES);
          n = $urandom_range(55, 65);
          for (int k = 0; k < n; k++) begin
            it     = random_item();
            it.cmd = bpm_pkg::CMD_TICK;
            it.mv  = healthy_voltage();
            send_item(it, 1'b0, NO_RES);
          end
          sent += n + 1;
        end else begin
          n = $urandom_range(5, 20);
          for (int k = 0; k < n; k++) send_item(random_item(), 1'b0, NO_RES);
          sent += n;
        end
      end
    end

    hold_and_drain();
    repeat (30) @(negedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("battery_power_mode_manager_unit verification clean");
    end else begin
      $display("battery_power_mode_manager_unit verification failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("battery_power_mode_manager_unit verification failed");
    $finish;
  end

endmodule
